// File: src/cmvs_pkg.sv
// cmvs_pkg: shared constants for the bit-plru miss victim selector
// default geometry used by the core and its port checker
// no dependencies
`default_nettype none

package cmvs_pkg;

    // default cache geometry
    localparam int WAYS_DEF       = 8;
    localparam int INDEX_BITS_DEF = 8;
    localparam int ADDR_BITS_DEF  = 32;

    // controller states
    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_BUSY  = 2'd2;

endpackage

`default_nettype wire

// File: src/cmvs_ram.sv
// cmvs_ram: generic single-port-write, single-port-read ram
// registered read data, no reset on contents
// no dependencies
`default_nettype none

module cmvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: src/cache_miss_victim_select_bit_plru_core.sv
// cache_miss_victim_select_bit_plru_core: miss handler with bit-plru victim choice
// per-set row (tags, mru word, valid word) kept in one cmvs_ram instance
// depends on cmvs_pkg and cmvs_ram
//
//  channel | valid       | stall        | payload
//  --------+-------------+--------------+-------------------------------------------
//  miss in | i_in_valid  | o_in_stall   | i_miss_address
//  result  | o_out_valid | i_out_stall  | o_victim_way, o_needs_writeback,
//          |             |              | o_writeback_address
//
// each miss first reads the set row from the ram, then picks the victim, writes
// the updated row back and loads the result register.
// after reset the ram is swept to zero, one set per cycle, over all 2**INDEX_BITS
// sets (256 at the default geometry); o_in_stall stays high during the sweep.
// a new miss is taken while a result still waits; a held result stalls the
// write-back cycle of the following miss until the result register frees up.
`default_nettype none

module cache_miss_victim_select_bit_plru_core #(
    parameter int WAYS       = cmvs_pkg::WAYS_DEF,
    parameter int INDEX_BITS = cmvs_pkg::INDEX_BITS_DEF,
    parameter int ADDR_BITS  = cmvs_pkg::ADDR_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [ADDR_BITS-1:0]     i_miss_address,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic      [$clog2(WAYS)-1:0]  o_victim_way,
    output logic                          o_needs_writeback,
    output logic      [ADDR_BITS-1:0]     o_writeback_address
);

    import cmvs_pkg::*;

    localparam int WAY_BITS  = $clog2(WAYS);
    localparam int TAG_BITS  = ADDR_BITS - INDEX_BITS;
    localparam int SETS      = 1 << INDEX_BITS;
    localparam int ROW_BITS  = WAYS * TAG_BITS + 2 * WAYS;

    typedef logic [ROW_BITS-1:0] t_row;

    logic [1:0]            r_state, n_state;
    logic [INDEX_BITS-1:0] r_clr_idx;
    logic [INDEX_BITS-1:0] r_set;
    logic [TAG_BITS-1:0]   r_tag;
    logic                  r_out_valid;
    logic [WAY_BITS-1:0]   r_way;
    logic                  r_evict;
    logic [ADDR_BITS-1:0]  r_wb_addr;

    logic                  in_xfer;
    logic                  commit;
    logic                  ram_we;
    logic [INDEX_BITS-1:0] ram_waddr;
    t_row                  ram_wdata;
    t_row                  rd_row;

    logic [WAYS-1:0]          cur_valid, cur_mru, pick, way_hot, mru_set;
    logic [WAYS-1:0]          new_valid, new_mru;
    logic [WAYS*TAG_BITS-1:0] cur_tags, new_tags;
    logic [TAG_BITS-1:0]      old_tag;
    logic [WAY_BITS-1:0]      way;
    logic                     evict;

    // input transfer and write-back conditions
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign commit     = (r_state == ST_BUSY) && (!r_out_valid || !i_out_stall);

    // set metadata and tags
    cmvs_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (SETS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_xfer),
        .i_raddr (i_miss_address[INDEX_BITS-1:0]),
        .o_rdata (rd_row)
    );

    // split the row read for the pending miss
    assign cur_valid = rd_row[WAYS-1:0];
    assign cur_mru   = rd_row[2*WAYS-1:WAYS];
    assign cur_tags  = rd_row[ROW_BITS-1:2*WAYS];
    assign evict     = &cur_valid;
    assign pick      = evict ? cur_mru : cur_valid;

    // lowest clear bit, way 0 when none is clear
    always_comb begin
        way = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (!pick[i]) begin
                way = WAY_BITS'(i);
            end
        end
    end

    // row update: new tag, valid bit, mru bits with wrap to the victim alone
    always_comb begin
        way_hot   = WAYS'(1) << way;
        old_tag   = cur_tags[way*TAG_BITS +: TAG_BITS];
        new_valid = cur_valid | way_hot;
        mru_set   = cur_mru | way_hot;
        new_mru   = (&mru_set) ? way_hot : mru_set;
        for (int i = 0; i < WAYS; i++) begin
            new_tags[i*TAG_BITS +: TAG_BITS] = (way == WAY_BITS'(i)) ?
                r_tag : cur_tags[i*TAG_BITS +: TAG_BITS];
        end
    end

    // ram write source: clearing sweep or miss write-back
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_set;
        ram_wdata = {new_tags, new_mru, new_valid};
        if (r_state == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_idx;
            ram_wdata = '0;
        end else if (commit) begin
            ram_we    = 1'b1;
        end
    end

    // controller next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_idx == {INDEX_BITS{1'b1}}) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // miss capture and result payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_set <= i_miss_address[INDEX_BITS-1:0];
            r_tag <= i_miss_address[ADDR_BITS-1:INDEX_BITS];
        end
        if (commit) begin
            r_way     <= way;
            r_evict   <= evict;
            r_wb_addr <= evict ? {old_tag, r_set} : '0;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_victim_way        = r_way;
    assign o_needs_writeback   = r_evict;
    assign o_writeback_address = r_wb_addr;

endmodule

`default_nettype wire

// File: src/cmvs_checker.sv
// cmvs_checker: port-level checks for the bit-plru miss victim selector
// bound to cache_miss_victim_select_bit_plru_core; depends on cmvs_pkg
`default_nettype none

module cmvs_checker #(
    parameter int WAYS       = cmvs_pkg::WAYS_DEF,
    parameter int INDEX_BITS = cmvs_pkg::INDEX_BITS_DEF,
    parameter int ADDR_BITS  = cmvs_pkg::ADDR_BITS_DEF
) (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_in_valid,
    input wire logic                    o_in_stall,
    input wire logic [ADDR_BITS-1:0]    i_miss_address,
    input wire logic                    o_out_valid,
    input wire logic                    i_out_stall,
    input wire logic [$clog2(WAYS)-1:0] o_victim_way,
    input wire logic                    o_needs_writeback,
    input wire logic [ADDR_BITS-1:0]    o_writeback_address
);

    import cmvs_pkg::*;

    logic in_xfer;
    assign in_xfer = i_in_valid && !o_in_stall;

    // clearing sweep blocks misses right after reset
    a_reset_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("miss input open right after reset");

    // block is busy the cycle after a miss transfer
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_in_stall)
        else $error("second miss taken before first was handled");

    // a new result only follows a busy cycle
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a miss in flight");

    // no writeback means a zero address
    a_wb_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_needs_writeback) |-> (o_writeback_address == '0))
        else $error("writeback address set without eviction");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_victim_way)
            && $stable(o_needs_writeback) && $stable(o_writeback_address)))
        else $error("stalled result changed");

endmodule

bind cache_miss_victim_select_bit_plru_core cmvs_checker #(
    .WAYS       (WAYS),
    .INDEX_BITS (INDEX_BITS),
    .ADDR_BITS  (ADDR_BITS)
) u_cmvs_checker (.*);

`default_nettype wire
